### rtl/core/hrhp_pkg.sv
// Package for the HTTP response header parser: phase and field-mode codes,
// the command and status structs between the top level and the value field unit.
// No dependencies.
package hrhp_pkg;

    localparam int DEF_MAX_HEADER_LINES = 32;

    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 6;   // width of the reported line count
    localparam int LEN_W   = 32;

    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_SP    = 8'h20;
    localparam logic [BYTE_W-1:0] CH_HT    = 8'h09;
    localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;

    localparam int NAME_LEN = 14;
    localparam int POS_W    = $clog2(NAME_LEN + 1);

    // Lower-case header name that selects the length field.
    localparam logic [BYTE_W-1:0] FIELD_NAME [NAME_LEN] = '{
        8'h63, 8'h6F, 8'h6E, 8'h74, 8'h65, 8'h6E, 8'h74,   // "content"
        8'h2D,                                             // "-"
        8'h6C, 8'h65, 8'h6E, 8'h67, 8'h74, 8'h68           // "length"
    };

    typedef enum logic [2:0] {
        PH_LINE_START = 3'd0,
        PH_IN_LINE    = 3'd1,
        PH_AFTER_CR   = 3'd2,
        PH_START_CR   = 3'd3,
        PH_PENDING    = 3'd4,
        PH_FOLDING    = 3'd5,
        PH_BODY       = 3'd6,
        PH_CLOSED     = 3'd7
    } t_phase;

    typedef enum logic [1:0] {
        VM_NAME   = 2'd0,
        VM_SKIP   = 2'd1,
        VM_DIGITS = 2'd2,
        VM_IGNORE = 2'd3
    } t_vmode;

    typedef enum logic [2:0] {
        FLD_HOLD    = 3'd0,   // keep the line state
        FLD_FEED    = 3'd1,   // feed one content byte
        FLD_KILL    = 3'd2,   // a stray CR entered the line: stop parsing it
        FLD_CLEAR   = 3'd3,   // start a fresh line
        FLD_RESTART = 3'd4    // start a fresh line and feed its first byte
    } t_fld_op;

    typedef struct packed {
        t_fld_op           op;
        logic [BYTE_W-1:0] data;
    } t_fld_cmd;

    typedef struct packed {
        logic             has_digit;
        logic [LEN_W-1:0] value;
    } t_fld_stat;

endpackage

### rtl/core/hrhp_value_field.sv
// Per-line state of the header parser: name match against Content-Length
// and the saturating decimal value after the colon. Depends on hrhp_pkg.
module hrhp_value_field (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  hrhp_pkg::t_fld_cmd i_cmd,
    output hrhp_pkg::t_fld_stat o_stat
);
    import hrhp_pkg::*;

    logic [POS_W-1:0] r_pos,   n_pos;
    t_vmode           r_mode,  n_mode;
    logic [LEN_W-1:0] r_accum, n_accum;
    logic             r_digit, n_digit;

    logic [POS_W-1:0]  b_pos;
    t_vmode            b_mode;
    logic [LEN_W-1:0]  b_accum;
    logic              b_digit;
    logic [BYTE_W-1:0] lc;
    logic [BYTE_W-1:0] name_ch;
    logic              is_dig;
    logic              is_lws;
    logic [LEN_W-1:0]  dig_val;
    logic [LEN_W+3:0]  prod;

    always_comb begin
        lc = i_cmd.data;
        if (i_cmd.data inside {[8'h41:8'h5A]}) begin
            lc = i_cmd.data + 8'h20;
        end
        is_dig  = i_cmd.data inside {[8'h30:8'h39]};
        is_lws  = (i_cmd.data == CH_SP) || (i_cmd.data == CH_HT);
        dig_val = LEN_W'(i_cmd.data - 8'h30);
        name_ch = 8'h00;
        if (r_pos < POS_W'(NAME_LEN) || b_pos < POS_W'(NAME_LEN)) begin
            name_ch = FIELD_NAME[b_pos];
        end
    end

    always_comb begin
        // base state: current line, or a cleared one for a new line
        b_pos   = r_pos;
        b_mode  = r_mode;
        b_accum = r_accum;
        b_digit = r_digit;
        if (i_cmd.op == FLD_CLEAR || i_cmd.op == FLD_RESTART) begin
            b_pos   = '0;
            b_mode  = VM_NAME;
            b_accum = '0;
            b_digit = 1'b0;
        end
    end

    always_comb begin
        // accum * 10 + digit, as shifts and adds
        prod = {1'b0, r_accum, 3'b000} + {3'b000, r_accum, 1'b0} + (LEN_W+4)'(dig_val);
    end

    always_comb begin
        n_pos   = b_pos;
        n_mode  = b_mode;
        n_accum = b_accum;
        n_digit = b_digit;
        case (i_cmd.op)
            FLD_FEED, FLD_RESTART: begin
                case (b_mode)
                    VM_NAME: begin
                        if (b_pos < POS_W'(NAME_LEN) && lc == name_ch) begin
                            n_pos = b_pos + 1'b1;
                        end else if (b_pos == POS_W'(NAME_LEN) && i_cmd.data == CH_COLON) begin
                            n_mode = VM_SKIP;
                        end else begin
                            n_mode = VM_IGNORE;
                        end
                    end
                    VM_SKIP: begin
                        if (is_dig) begin
                            n_accum = dig_val;
                            n_digit = 1'b1;
                            n_mode  = VM_DIGITS;
                        end else if (!is_lws) begin
                            n_mode = VM_IGNORE;
                        end
                    end
                    VM_DIGITS: begin
                        if (is_dig) begin
                            n_accum = (prod[LEN_W+3:LEN_W] != '0) ? '1 : prod[LEN_W-1:0];
                        end else begin
                            n_mode = VM_IGNORE;
                        end
                    end
                    default: ;
                endcase
            end
            FLD_KILL: begin
                n_mode = VM_IGNORE;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_mode  <= VM_NAME;
            r_accum <= '0;
            r_digit <= 1'b0;
        end else begin
            r_pos   <= n_pos;
            r_mode  <= n_mode;
            r_accum <= n_accum;
            r_digit <= n_digit;
        end
    end

    assign o_stat.has_digit = r_digit;
    assign o_stat.value     = r_accum;

endmodule

### rtl/core/http_response_header_parser.sv
// Top level of the HTTP response header parser: phase state machine, line
// counting, length capture and the output register. Depends on hrhp_pkg and
// hrhp_value_field.
//
// Takes one response byte (or a connection-close mark in tuser) per transfer and
// returns exactly one result per transfer. Throughput is one item per clock unless the
// output stalls: the whole update is a single pass from the accepted item through the
// phase machine and the per-line field unit into the state and output registers, so
// the result is valid in the cycle after the input transfer. The output register is a
// single stage; s_axis_tready stays high while the result register is empty or being
// drained in the same cycle. A line is reported (line_ended) with the item after
// its CRLF, once that byte is known not to start a fold. After a close, further
// items are consumed and produce results with the status held.
module http_response_header_parser #(
    parameter int MAX_HEADER_LINES = hrhp_pkg::DEF_MAX_HEADER_LINES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] closed
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] header_done, [1] line_ended, [7:2] line_count, [8] lines_overflow,
    // [40:9] content_length, [41] length_known, [42] body_valid,
    // [50:43] body_byte, [51] malformed, [55:52] zero
    output logic [55:0] m_axis_tdata
);
    import hrhp_pkg::*;

    localparam int LINES_W = $clog2(MAX_HEADER_LINES + 1);

    // State registers
    t_phase             r_phase,    n_phase;
    logic [LINES_W-1:0] r_lines,    n_lines;
    logic               r_overflow, n_overflow;
    logic [LEN_W-1:0]   r_length,   n_length;
    logic               r_len_seen, n_len_seen;
    logic               r_hdr_done, n_hdr_done;
    logic               r_bad_close, n_bad_close;

    // Output register
    logic               r_out_valid;
    logic [55:0]        r_out_data;

    logic               acc;
    logic [BYTE_W-1:0]  c;
    logic               close;
    logic               c_lws;
    logic               commit;
    logic               ended;
    logic               bvalid;
    logic               set_hdr;
    logic               set_bad;
    t_fld_cmd           fld_cmd;
    t_fld_stat          fld_stat;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign acc   = s_axis_tvalid && s_axis_tready;
    assign c     = s_axis_tdata;
    assign close = s_axis_tuser;
    assign c_lws = (c == CH_SP) || (c == CH_HT);

    hrhp_value_field u_field (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (fld_cmd),
        .o_stat (fld_stat)
    );

    // Next phase
    always_comb begin
        n_phase = r_phase;
        if (acc) begin
            if (close) begin
                n_phase = PH_CLOSED;
            end else begin
                case (r_phase)
                    PH_LINE_START, PH_PENDING: begin
                        if (c == CH_CR) begin
                            n_phase = PH_START_CR;
                        end else if (r_phase == PH_PENDING && c_lws) begin
                            n_phase = PH_FOLDING;
                        end else begin
                            n_phase = PH_IN_LINE;
                        end
                    end
                    PH_IN_LINE: begin
                        n_phase = (c == CH_CR) ? PH_AFTER_CR : PH_IN_LINE;
                    end
                    PH_AFTER_CR, PH_START_CR: begin
                        if (c == CH_LF) begin
                            n_phase = (r_phase == PH_AFTER_CR) ? PH_PENDING : PH_BODY;
                        end else begin
                            n_phase = (c == CH_CR) ? PH_AFTER_CR : PH_IN_LINE;
                        end
                    end
                    PH_FOLDING: begin
                        if (!c_lws) begin
                            n_phase = (c == CH_CR) ? PH_AFTER_CR : PH_IN_LINE;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // Actions per phase: field unit command, line commit, status flags
    always_comb begin
        fld_cmd.op   = FLD_HOLD;
        fld_cmd.data = c;
        commit  = 1'b0;
        ended   = 1'b0;
        bvalid  = 1'b0;
        set_hdr = 1'b0;
        set_bad = 1'b0;
        if (acc) begin
            if (close) begin
                case (r_phase)
                    PH_LINE_START: set_hdr = 1'b1;
                    PH_PENDING: begin
                        commit      = 1'b1;
                        ended       = 1'b1;
                        set_hdr     = 1'b1;
                        fld_cmd.op  = FLD_CLEAR;
                    end
                    PH_IN_LINE, PH_AFTER_CR, PH_START_CR, PH_FOLDING: set_bad = 1'b1;
                    default: ;
                endcase
            end else begin
                case (r_phase)
                    PH_LINE_START, PH_IN_LINE: begin
                        if (c != CH_CR) fld_cmd.op = FLD_FEED;
                    end
                    PH_AFTER_CR, PH_START_CR: begin
                        if (c != CH_LF) begin
                            // the held CR is line content, which ends any parse
                            fld_cmd.op = FLD_KILL;
                        end else if (r_phase == PH_START_CR) begin
                            set_hdr = 1'b1;
                        end
                    end
                    PH_PENDING: begin
                        if (c_lws) begin
                            // fold: the CRLF and blanks become one space
                            fld_cmd.op   = FLD_FEED;
                            fld_cmd.data = CH_SP;
                        end else begin
                            commit     = 1'b1;
                            ended      = 1'b1;
                            fld_cmd.op = (c == CH_CR) ? FLD_CLEAR : FLD_RESTART;
                        end
                    end
                    PH_FOLDING: begin
                        if (!c_lws && c != CH_CR) fld_cmd.op = FLD_FEED;
                    end
                    PH_BODY: bvalid = 1'b1;
                    default: ;
                endcase
            end
        end
    end

    // Counters and sticky status
    always_comb begin
        n_lines     = r_lines;
        n_overflow  = r_overflow;
        n_length    = r_length;
        n_len_seen  = r_len_seen;
        n_hdr_done  = r_hdr_done || set_hdr;
        n_bad_close = r_bad_close || set_bad;
        if (commit) begin
            // saturate the count at the bound; flag lines beyond it
            if (r_lines < LINES_W'(MAX_HEADER_LINES)) begin
                n_lines = r_lines + 1'b1;
            end else begin
                n_overflow = 1'b1;
            end
            if (fld_stat.has_digit) begin
                n_length   = fld_stat.value;
                n_len_seen = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_LINE_START;
            r_lines     <= '0;
            r_overflow  <= 1'b0;
            r_length    <= '0;
            r_len_seen  <= 1'b0;
            r_hdr_done  <= 1'b0;
            r_bad_close <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_lines     <= n_lines;
            r_overflow  <= n_overflow;
            r_length    <= n_length;
            r_len_seen  <= n_len_seen;
            r_hdr_done  <= n_hdr_done;
            r_bad_close <= n_bad_close;
            if (acc) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload: load on every input transfer, hold while stalled
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_out_data <= {4'b0000,
                           n_bad_close,
                           bvalid ? c : 8'h00,
                           bvalid,
                           n_len_seen,
                           n_length,
                           n_overflow,
                           COUNT_W'(n_lines),
                           ended,
                           n_hdr_done};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // A committed line always leaves a nonzero count behind.
    a_commit_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |=> (r_lines != '0))
        else $error("line committed but count is zero");

    // A clean end of headers and a bad close exclude each other.
    a_done_xor_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_hdr_done && r_bad_close))
        else $error("header_done and malformed both set");

    // Body bytes only flow once the header section has ended.
    a_body_after_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data[42]) |-> r_out_data[0])
        else $error("body byte before end of headers");

    // Only the body phase produces body data.
    a_body_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        bvalid |-> (r_phase == PH_BODY) && r_hdr_done)
        else $error("body data outside body phase");

endmodule
